// ===== rtl/gkee_pkg.sv =====
// Package for the gamepad key event encoder.
// Holds the item structs, zone and key codes, register indexes and the button key table.
// No dependencies; every other file in rtl imports it.
package gkee_pkg;

   localparam int MAPPED_BUTTONS = 6;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 10;

   localparam logic [9:0] CENTER_RESET = 10'd512;
   localparam logic [8:0] DEADZONE_RESET = 9'd200;
   localparam logic [7:0] INTERVAL_RESET = 8'd20;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PAD_PRESENT  = 2'd0,
      CSR_STICK_CENTER = 2'd1,
      CSR_DEADZONE     = 2'd2,
      CSR_INTERVAL     = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ZONE_NEUTRAL = 2'd0,
      ZONE_PLUS    = 2'd1,
      ZONE_MINUS   = 2'd2
   } zone_type;

   localparam logic [3:0] KEY_USE = 4'd0;
   localparam logic [3:0] KEY_SHOOT = 4'd1;
   localparam logic [3:0] KEY_SIDESTEP_R = 4'd2;
   localparam logic [3:0] KEY_SIDESTEP_L = 4'd3;
   localparam logic [3:0] KEY_CONFIRM = 4'd4;
   localparam logic [3:0] KEY_TAB = 4'd5;
   localparam logic [3:0] KEY_RIGHT = 4'd6;
   localparam logic [3:0] KEY_LEFT = 4'd7;
   localparam logic [3:0] KEY_UP = 4'd8;
   localparam logic [3:0] KEY_DOWN = 4'd9;

   typedef struct packed {
      logic [5:0]  button_levels;
      logic [9:0]  stick_x;
      logic [9:0]  stick_y;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic       event_valid;
      logic       key_pressed;
      logic [3:0] key_id;
   } rsp_type;

   typedef struct packed {
      logic       found;
      logic [3:0] key_id;
   } pick_type;

   typedef struct packed {
      logic below;
      logic above;
   } axis_cmp_type;

   // Button order: select, b, y, a, x, start.
   function automatic logic [3:0] button_key(input logic [2:0] idx);
      logic [3:0] key;
      unique case (idx)
         3'd0:    key = KEY_TAB;
         3'd1:    key = KEY_SHOOT;
         3'd2:    key = KEY_SIDESTEP_L;
         3'd3:    key = KEY_USE;
         3'd4:    key = KEY_SIDESTEP_R;
         3'd5:    key = KEY_CONFIRM;
         default: key = KEY_USE;
      endcase
      return key;
   endfunction

endpackage

// ===== rtl/gamepad_key_event_encoder_unit.sv =====
// Top level of the gamepad key event encoder.
// Depends on gkee_pkg, gkee_button_pick and gkee_axis_compare.

// One poll goes in per item and exactly one result item comes out, carrying at most one key
// event. A poll is taken into an input register and evaluated there by one pass of
// combinational logic (button priority pick, two axis compares, elapsed-time compare)
// that updates the button, zone and time state and loads the result register. A new
// poll can be accepted every cycle while rsp_stall does not hold the result register;
// the rate is set by that single evaluation stage and by the result register, which
// lets the next poll enter while a result waits. req_stall rises only when the input
// register is full and the result register is held by rsp_stall. Configuration writes
// are always ready and must be made while idle.
module gamepad_key_event_encoder_unit #(
   parameter int BUTTON_COUNT = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  gkee_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output gkee_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [gkee_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [gkee_pkg::CSR_DATA_W-1:0]   csr_data
);
   import gkee_pkg::*;

   localparam int EXT_W = (BUTTON_COUNT > MAPPED_BUTTONS) ? BUTTON_COUNT : MAPPED_BUTTONS;

   // Configuration registers.
   logic        pad_present_ff;
   logic [9:0]  center_ff;
   logic [8:0]  deadzone_ff;
   logic [7:0]  interval_ff;

   // Pipeline registers.
   logic    in_valid_ff;
   req_type in_data_ff;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;

   // Poll state.
   logic [BUTTON_COUNT-1:0] known_ff;
   logic [BUTTON_COUNT-1:0] known_in;
   zone_type                x_zone_ff;
   zone_type                x_zone_in;
   zone_type                y_zone_ff;
   zone_type                y_zone_in;
   logic [31:0]             last_time_ff;
   logic [31:0]             last_time_in;

   logic                    out_free;
   logic                    advance;
   logic                    req_accept;
   logic [5:0]              pressed_raw;
   logic [EXT_W-1:0]        pressed_ext;
   logic [BUTTON_COUNT-1:0] pressed_now;
   logic [BUTTON_COUNT-1:0] changed;
   logic [BUTTON_COUNT-1:0] sel_onehot;
   pick_type                pick;
   axis_cmp_type            x_cmp;
   axis_cmp_type            y_cmp;
   zone_type                x_new;
   zone_type                y_new;
   logic [31:0]             elapsed;
   logic                    stick_due;
   rsp_type                 result;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // Buttons above the six wired ones always read as released.
   assign pressed_raw = ~in_data_ff.button_levels;
   assign pressed_ext = EXT_W'(pressed_raw);
   assign pressed_now = pressed_ext[BUTTON_COUNT-1:0];
   assign changed = pressed_now ^ known_ff;

   gkee_button_pick #(
      .BUTTON_COUNT(BUTTON_COUNT)
   ) u_pick (
      .changed   (changed),
      .pick      (pick),
      .sel_onehot(sel_onehot)
   );

   gkee_axis_compare u_x_cmp (
      .sample  (in_data_ff.stick_x),
      .center  (center_ff),
      .deadzone(deadzone_ff),
      .cmp     (x_cmp)
   );

   gkee_axis_compare u_y_cmp (
      .sample  (in_data_ff.stick_y),
      .center  (center_ff),
      .deadzone(deadzone_ff),
      .cmp     (y_cmp)
   );

   assign elapsed = in_data_ff.now_ms - last_time_ff;
   assign stick_due = elapsed > {24'd0, interval_ff};

   // The y axis points up when the sample is low.
   assign x_new = x_cmp.below ? ZONE_MINUS : (x_cmp.above ? ZONE_PLUS : ZONE_NEUTRAL);
   assign y_new = y_cmp.below ? ZONE_PLUS : (y_cmp.above ? ZONE_MINUS : ZONE_NEUTRAL);

   always_comb begin
      known_in = known_ff;
      x_zone_in = x_zone_ff;
      y_zone_in = y_zone_ff;
      last_time_in = last_time_ff;
      result = '0;
      if (pad_present_ff) begin
         if (pick.found) begin
            known_in = known_ff ^ sel_onehot;
            result.event_valid = 1'b1;
            result.key_pressed = |(pressed_now & sel_onehot);
            result.key_id = pick.key_id;
         end else begin
            // Changes only on unmapped buttons are absorbed without an event.
            if (changed != '0) begin
               known_in = pressed_now;
            end
            if (stick_due) begin
               last_time_in = in_data_ff.now_ms;
               // A direction change releases first and presses on a later poll.
               // The x keys are swapped: minus gives right, plus gives left.
               priority if (x_new != x_zone_ff && x_zone_ff != ZONE_NEUTRAL) begin
                  result.event_valid = 1'b1;
                  result.key_id = (x_zone_ff == ZONE_MINUS) ? KEY_RIGHT : KEY_LEFT;
                  x_zone_in = ZONE_NEUTRAL;
               end else if (x_new != x_zone_ff && x_new != ZONE_NEUTRAL) begin
                  result.event_valid = 1'b1;
                  result.key_pressed = 1'b1;
                  result.key_id = (x_new == ZONE_MINUS) ? KEY_RIGHT : KEY_LEFT;
                  x_zone_in = x_new;
               end else if (y_new != y_zone_ff && y_zone_ff != ZONE_NEUTRAL) begin
                  result.event_valid = 1'b1;
                  result.key_id = (y_zone_ff == ZONE_PLUS) ? KEY_UP : KEY_DOWN;
                  y_zone_in = ZONE_NEUTRAL;
               end else if (y_new != y_zone_ff && y_new != ZONE_NEUTRAL) begin
                  result.event_valid = 1'b1;
                  result.key_pressed = 1'b1;
                  result.key_id = (y_new == ZONE_PLUS) ? KEY_UP : KEY_DOWN;
                  y_zone_in = y_new;
               end else begin
                  result = '0;
               end
            end
         end
      end
   end

   always_comb begin
      if (out_free) begin
         rsp_valid_in = advance;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_present_ff <= 1'b0;
         center_ff <= CENTER_RESET;
         deadzone_ff <= DEADZONE_RESET;
         interval_ff <= INTERVAL_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PAD_PRESENT:  pad_present_ff <= csr_data[0];
            CSR_STICK_CENTER: center_ff <= csr_data[9:0];
            CSR_DEADZONE:     deadzone_ff <= csr_data[8:0];
            CSR_INTERVAL:     interval_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         known_ff <= '0;
         x_zone_ff <= ZONE_NEUTRAL;
         y_zone_ff <= ZONE_NEUTRAL;
         last_time_ff <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            known_ff <= known_in;
            x_zone_ff <= x_zone_in;
            y_zone_ff <= y_zone_in;
            last_time_ff <= last_time_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   // With the pad absent a poll must come out without an event.
   a_no_event_without_pad: assert property (@(posedge clock) disable iff (reset)
      advance && !pad_present_ff |=> rsp_valid && !rsp_data.event_valid)
      else $error("event produced while pad absent");

   // Every shown event carries a defined key code.
   a_key_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_valid |-> rsp_data.key_id <= KEY_DOWN)
      else $error("key code out of range");

   // The input side only stalls while a full input register cannot move on.
   a_stall_only_when_blocked: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("input stalled without a blocked result");

   // An item in the input register that can move on reaches the result register.
   a_item_moves: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !rsp_stall |=> rsp_valid)
      else $error("item lost between input and result registers");

endmodule

// ===== rtl/gkee_button_pick.sv =====
// Priority pick of the lowest-numbered changed button among the mapped ones and its key code.
// Depends on gkee_pkg.
module gkee_button_pick #(
   parameter int BUTTON_COUNT = 6
) (
   input  logic [BUTTON_COUNT-1:0] changed,
   output gkee_pkg::pick_type      pick,
   output logic [BUTTON_COUNT-1:0] sel_onehot
);
   import gkee_pkg::*;

   localparam int MAPPED = (BUTTON_COUNT < MAPPED_BUTTONS) ? BUTTON_COUNT : MAPPED_BUTTONS;

   // Walk from the top down so the lowest changed button wins.
   always_comb begin
      pick = '0;
      sel_onehot = '0;
      for (int i = MAPPED - 1; i >= 0; i--) begin
         if (changed[i]) begin
            pick.found = 1'b1;
            pick.key_id = button_key(3'(i));
            sel_onehot = '0;
            sel_onehot[i] = 1'b1;
         end
      end
   end

endmodule

// ===== rtl/gkee_axis_compare.sv =====
// Compares one joystick sample against the center plus and minus the deadzone.
// Depends on gkee_pkg.
module gkee_axis_compare (
   input  logic [9:0]             sample,
   input  logic [9:0]             center,
   input  logic [8:0]             deadzone,
   output gkee_pkg::axis_cmp_type cmp
);
   import gkee_pkg::*;

   logic [10:0] sample_plus_dz;
   logic [10:0] center_plus_dz;

   // sample < center - deadzone is tested as sample + deadzone < center, which
   // also covers a low bound that would fall below zero.
   assign sample_plus_dz = {1'b0, sample} + {2'b00, deadzone};
   assign center_plus_dz = {1'b0, center} + {2'b00, deadzone};

   assign cmp.below = sample_plus_dz < {1'b0, center};
   assign cmp.above = {1'b0, sample} > center_plus_dz;

endmodule

// ===== sim/tb.sv =====
// Testbench for gamepad_key_event_encoder_unit: directed and random polls checked
// against a predictor of the button and joystick event logic kept in this file.
// Depends on gkee_pkg and the encoder RTL only.
`timescale 1ns / 100ps

module tb;
   import gkee_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int MAX_REPORTS = 10;

   // Key code per button number, in the order select, b, y, a, x, start.
   localparam logic [3:0] BUTTON_TO_KEY [MAPPED_BUTTONS] = '{
      KEY_TAB, KEY_SHOOT, KEY_SIDESTEP_L, KEY_USE, KEY_SIDESTEP_R, KEY_CONFIRM
   };

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   // Predictor copy of configuration and state.
   logic        m_pad;
   logic [9:0]  m_center;
   logic [8:0]  m_deadzone;
   logic [7:0]  m_interval;
   logic [5:0]  m_buttons;
   zone_type    m_x_zone;
   zone_type    m_y_zone;
   logic [31:0] m_last_time;

   rsp_type pending_events [$];
   int      mismatch_count = 0;
   int      cycle_count = 0;
   bit      req_idle_on = 1'b1;
   bit      rsp_idle_on = 1'b1;
   int      hold_off_left = 0;
   int      stall_left = 0;

   // Current well-formed poll stream.
   logic [5:0]  poll_levels;
   logic [9:0]  poll_x;
   logic [9:0]  poll_y;
   logic [31:0] poll_time;

   gamepad_key_event_encoder_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic zone_type zone_of(input logic [9:0] sample, input zone_type low_zone,
                                        input zone_type high_zone);
      int s;
      int lo;
      int hi;
      s = int'(sample);
      lo = int'(m_center) - int'(m_deadzone);
      hi = int'(m_center) + int'(m_deadzone);
      if (s < lo) return low_zone;
      if (s > hi) return high_zone;
      return ZONE_NEUTRAL;
   endfunction

   // Note the x keys are swapped: the minus zone maps to right, plus to left.
   function automatic logic [3:0] x_key(input zone_type z);
      return (z == ZONE_MINUS) ? KEY_RIGHT : KEY_LEFT;
   endfunction

   function automatic logic [3:0] y_key(input zone_type z);
      return (z == ZONE_PLUS) ? KEY_UP : KEY_DOWN;
   endfunction

   function automatic rsp_type encode_key_event(input req_type poll);
      rsp_type    ev;
      logic [5:0] pressed;
      logic [5:0] changed;
      logic [31:0] elapsed;
      zone_type   nx;
      zone_type   ny;
      ev = '0;
      if (!m_pad) return ev;
      pressed = ~poll.button_levels;
      changed = pressed ^ m_buttons;
      for (int i = 0; i < MAPPED_BUTTONS; i++) begin
         if (changed[i]) begin
            m_buttons[i] = ~m_buttons[i];
            ev.event_valid = 1'b1;
            ev.key_pressed = pressed[i];
            ev.key_id = BUTTON_TO_KEY[i];
            return ev;
         end
      end
      elapsed = poll.now_ms - m_last_time;
      if (elapsed > {24'd0, m_interval}) begin
         nx = zone_of(poll.stick_x, ZONE_MINUS, ZONE_PLUS);
         ny = zone_of(poll.stick_y, ZONE_PLUS, ZONE_MINUS);
         m_last_time = poll.now_ms;
         if (nx != m_x_zone) begin
            if (m_x_zone != ZONE_NEUTRAL) begin
               ev = '{1'b1, 1'b0, x_key(m_x_zone)};
               m_x_zone = ZONE_NEUTRAL;
               return ev;
            end
            if (nx != ZONE_NEUTRAL) begin
               ev = '{1'b1, 1'b1, x_key(nx)};
               m_x_zone = nx;
               return ev;
            end
         end
         if (ny != m_y_zone) begin
            if (m_y_zone != ZONE_NEUTRAL) begin
               ev = '{1'b1, 1'b0, y_key(m_y_zone)};
               m_y_zone = ZONE_NEUTRAL;
               return ev;
            end
            if (ny != ZONE_NEUTRAL) begin
               ev = '{1'b1, 1'b1, y_key(ny)};
               m_y_zone = ny;
               return ev;
            end
         end
      end
      return ev;
   endfunction

   function automatic req_type make_poll(input logic [5:0] levels, input logic [9:0] x,
                                         input logic [9:0] y, input logic [31:0] t);
      req_type poll;
      poll.button_levels = levels;
      poll.stick_x = x;
      poll.stick_y = y;
      poll.now_ms = t;
      return poll;
   endfunction

   // Samples cluster around the zone edges so that both sides of each compare are hit.
   function automatic logic [9:0] stick_sample();
      int lo;
      int hi;
      int v;
      lo = int'(m_center) - int'(m_deadzone);
      hi = int'(m_center) + int'(m_deadzone);
      case ($urandom_range(0, 5))
         0: v = int'($urandom_range(0, 1023));
         1: v = lo + int'($urandom_range(0, 4)) - 2;
         2: v = hi + int'($urandom_range(0, 4)) - 2;
         3: v = int'(m_center);
         4: v = 0;
         default: v = 1023;
      endcase
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      return v[9:0];
   endfunction

   // Receiver: random stall bursts plus an optional long hold-off.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_off_left > 0) begin
         rsp_stall <= 1'b1;
         hold_off_left--;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (rsp_idle_on && $urandom_range(0, 9) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 16);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_events.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("ERROR: result with no poll pending: got %p", rsp_data);
         end else begin
            want = pending_events.pop_front();
            if (rsp_data.event_valid !== want.event_valid ||
                rsp_data.key_pressed !== want.key_pressed ||
                rsp_data.key_id !== want.key_id) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("ERROR: key event mismatch: expected %p got %p", want, rsp_data);
            end
         end
      end
   end

   task automatic send_poll(input req_type poll);
      @(negedge clock);
      if (req_idle_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= poll;
      do @(posedge clock); while (req_stall);
      pending_events.push_back(encode_key_event(poll));
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [9:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_PAD_PRESENT:  m_pad = value[0];
         CSR_STICK_CENTER: m_center = value;
         CSR_DEADZONE:     m_deadzone = value[8:0];
         CSR_INTERVAL:     m_interval = value[7:0];
         default:          ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input logic pad, input logic [9:0] center,
                             input logic [8:0] deadzone, input logic [7:0] interval);
      wait_idle();
      csr_write(CSR_PAD_PRESENT, {9'd0, pad});
      csr_write(CSR_STICK_CENTER, center);
      csr_write(CSR_DEADZONE, {1'b0, deadzone});
      csr_write(CSR_INTERVAL, {2'd0, interval});
   endtask

   // Mostly plausible poll streams: held buttons, advancing time, sticky samples.
   task automatic run_polls(input int count, input int noise_pct);
      req_type poll;
      int      flip_idx;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < noise_pct) begin
            poll = make_poll(6'($urandom_range(0, 63)), 10'($urandom_range(0, 1023)),
                             10'($urandom_range(0, 1023)), $urandom());
         end else begin
            if ($urandom_range(0, 5) == 0) begin
               flip_idx = int'($urandom_range(0, 5));
               poll_levels[flip_idx] = ~poll_levels[flip_idx];
            end
            if ($urandom_range(0, 19) == 0)
               poll_levels = 6'($urandom_range(0, 63));
            poll_time += $urandom_range(0, 2 * int'(m_interval) + 2);
            if ($urandom_range(0, 2) == 0) poll_x = stick_sample();
            if ($urandom_range(0, 2) == 0) poll_y = stick_sample();
            poll = make_poll(poll_levels, poll_x, poll_y, poll_time);
         end
         send_poll(poll);
      end
   endtask

   task automatic test_pad_absent();
      send_poll(make_poll(6'h00, 10'd0, 10'd1023, 32'd1000));
      send_poll(make_poll(6'h2A, 10'd1023, 10'd0, 32'd5000));
   endtask

   // Every button pressed at once comes out one per poll, lowest number first.
   task automatic test_buttons();
      set_config(1'b1, CENTER_RESET, DEADZONE_RESET, INTERVAL_RESET);
      repeat (6) send_poll(make_poll(6'h00, 10'd512, 10'd512, 32'd0));
      repeat (6) send_poll(make_poll(6'h3F, 10'd512, 10'd512, 32'd0));
   endtask

   // Direction changes, swapped x keys, wrapped time, the interval edge and zone bounds.
   task automatic test_stick();
      send_poll(make_poll(6'h3F, 10'd0, 10'd512, 32'hFFFF_FFF0));
      send_poll(make_poll(6'h3F, 10'd1023, 10'd512, 32'd5));
      send_poll(make_poll(6'h3F, 10'd1023, 10'd512, 32'd26));
      send_poll(make_poll(6'h3F, 10'd512, 10'd512, 32'd40));
      send_poll(make_poll(6'h3F, 10'd512, 10'd0, 32'd47));
      send_poll(make_poll(6'h3F, 10'd512, 10'd0, 32'd68));
      send_poll(make_poll(6'h3F, 10'd512, 10'd1023, 32'd89));
      send_poll(make_poll(6'h3F, 10'd512, 10'd1023, 32'd110));
      send_poll(make_poll(6'h3F, 10'd512, 10'd712, 32'd131));
      send_poll(make_poll(6'h3F, 10'd712, 10'd312, 32'd152));
      send_poll(make_poll(6'h3F, 10'd713, 10'd312, 32'd173));
   endtask

   task automatic test_random_settings();
      set_config(1'b1, 10'd0, 9'd511, 8'd0);
      run_polls(220, 10);
      set_config(1'b1, 10'd1023, 9'd0, 8'd255);
      run_polls(220, 10);
      set_config(1'b1, 10'd100, 9'd300, 8'd5);
      run_polls(220, 10);
      set_config(1'b0, 10'd512, 9'd200, 8'd20);
      run_polls(50, 20);
      set_config(1'b1, 10'd1023, 9'd511, 8'd1);
      run_polls(220, 10);
      set_config(1'b1, CENTER_RESET, DEADZONE_RESET, INTERVAL_RESET);
      run_polls(220, 10);
      repeat (2) begin
         set_config(1'b1, 10'($urandom_range(0, 1023)), 9'($urandom_range(0, 511)),
                    8'($urandom_range(0, 255)));
         poll_time = $urandom();
         run_polls(150, 10);
      end
   endtask

   // The receiver holds off long enough for the block to fill and stall its input.
   task automatic test_input_backpressure();
      wait_idle();
      hold_off_left = 400;
      run_polls(150, 10);
   endtask

   task automatic test_full_rate();
      wait_idle();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      run_polls(250, 5);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = CSR_PAD_PRESENT;
      csr_data = '0;
      m_pad = 1'b0;
      m_center = CENTER_RESET;
      m_deadzone = DEADZONE_RESET;
      m_interval = INTERVAL_RESET;
      m_buttons = '0;
      m_x_zone = ZONE_NEUTRAL;
      m_y_zone = ZONE_NEUTRAL;
      m_last_time = '0;
      poll_levels = 6'h3F;
      poll_x = 10'd512;
      poll_y = 10'd512;
      poll_time = 32'd200;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_pad_absent();
      test_buttons();
      test_stick();
      test_random_settings();
      test_input_backpressure();
      test_full_rate();

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
